[design/ceba_pkg.sv]
// ----------------------------------------------------------------------------
// ceba_pkg: shared types and constants for the extent block allocator
// Request and result payloads, operation and status codes, sequencer states
// and the word unit result record.
// ----------------------------------------------------------------------------
package ceba_pkg;

  localparam int CEBA_MAX_BLOCKS      = 4096;
  localparam int CEBA_RESERVED_BLOCKS = 4;
  localparam int DISK_RESET           = 1024;

  localparam int WORD_W  = 64;
  localparam int WORD_BW = 6;
  localparam int CNT_W   = 7;
  localparam int BLK_W   = 12;
  localparam int LEN_W   = 13;

  typedef enum logic [1:0] {
    KIND_GROW    = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_FORMAT  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_FREE    = 2'd1,
    ST_DISK_FULL  = 2'd2,
    ST_NEXT_TAKEN = 2'd3
  } status_t;

  typedef struct packed {
    kind_t             kind;
    logic [BLK_W-1:0]  extent_start;
    logic [LEN_W-1:0]  extent_length;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [BLK_W-1:0]  new_start;
    logic [LEN_W-1:0]  new_length;
    logic [LEN_W-1:0]  free_count;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_LOOP,
    S_RFIN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic               found;
    logic [WORD_BW-1:0] idx;
    logic [CNT_W-1:0]   count;
    logic [WORD_W-1:0]  claimed;
    logic [WORD_W-1:0]  cleared;
  } word_res_t;

endpackage

[design/ceba_word_unit.sv]
// ----------------------------------------------------------------------------
// ceba_word_unit: usage word search, claim and release unit
// Finds the lowest clear bit under a mask, counts the set bits under the
// mask, and forms the claimed and the cleared word.
// ----------------------------------------------------------------------------
module ceba_word_unit (
  input  logic [ceba_pkg::WORD_W-1:0] word,
  input  logic [ceba_pkg::WORD_W-1:0] mask,
  output ceba_pkg::word_res_t         res
);
  import ceba_pkg::*;

  localparam int GRP  = 8;
  localparam int NGRP = WORD_W / GRP;
  localparam int GW   = $clog2(NGRP);
  localparam int BW2  = $clog2(GRP);

  logic [WORD_W-1:0] open_bits;
  logic [WORD_W-1:0] hit_bits;
  logic [NGRP-1:0]   grp_any;
  logic [GW-1:0]     gsel;
  logic [BW2-1:0]    bsel;
  logic [GRP-1:0]    gbits;
  logic [BW2:0]      gcnt [NGRP];
  logic [CNT_W-1:0]  total;

  always_comb begin
    open_bits = ~word & mask;
    hit_bits  = word & mask;
    for (int g = 0; g < NGRP; g++) begin
      grp_any[g] = |open_bits[g*GRP +: GRP];
    end
    gsel = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        gsel = GW'(g);
      end
    end
    gbits = open_bits[gsel*GRP +: GRP];
    bsel  = '0;
    for (int b = GRP - 1; b >= 0; b--) begin
      if (gbits[b]) begin
        bsel = BW2'(b);
      end
    end
    total = '0;
    for (int g = 0; g < NGRP; g++) begin
      gcnt[g] = '0;
      for (int b = 0; b < GRP; b++) begin
        gcnt[g] = gcnt[g] + (BW2+1)'(hit_bits[g*GRP+b]);
      end
      total = total + CNT_W'(gcnt[g]);
    end
    res.found   = |grp_any;
    res.idx     = {gsel, bsel};
    res.count   = total;
    res.claimed = word | (WORD_W'(1) << {gsel, bsel});
    res.cleared = word & ~mask;
  end

endmodule

[design/contiguous_extent_block_allocator.sv]
// ----------------------------------------------------------------------------
// contiguous_extent_block_allocator: first-fit usage map block allocator
// Keeps one usage bit per block in a 64-bit-wide map memory and a free count.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_stall/in_data: grow an extent by one block,
// release an extent, or format the map. Each request gives one result on
// out_valid/out_stall/out_data. cfg_we/cfg_wdata set the disk size.
// One request is worked at a time; in_stall is high from acceptance until
// the result is loaded into the output register. The map is walked one
// 64-bit row per cycle through one shared word unit; rows walked:
//   grow of an empty extent: rows scanned (up to MAX_BLOCKS/64)
//   grow of a non-empty extent: the row of the block after the extent, none when it fails at once
//   release: rows covered by the extent on the disk, none when none are
//   format: every row (clearing pass)
//   other requests: none
// After reset a clearing pass over every row runs with in_stall
// high; configuration writes are taken during it. A stalled result holds in
// the output register while the next request is accepted and worked; that
// request's result then waits until the output register is free.
// ----------------------------------------------------------------------------
module contiguous_extent_block_allocator #(
  parameter int MAX_BLOCKS      = ceba_pkg::CEBA_MAX_BLOCKS,
  parameter int RESERVED_BLOCKS = ceba_pkg::CEBA_RESERVED_BLOCKS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  ceba_pkg::req_t             in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output ceba_pkg::res_t             out_data,
  input  logic                       cfg_we,
  input  logic [ceba_pkg::LEN_W-1:0] cfg_wdata
);
  import ceba_pkg::*;

  localparam int ROWS     = MAX_BLOCKS / WORD_W;
  localparam int RW       = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int RES_ROW  = RESERVED_BLOCKS / WORD_W;
  localparam int RES_BIT  = RESERVED_BLOCKS % WORD_W;
  localparam int T_RST    = (DISK_RESET > MAX_BLOCKS) ? MAX_BLOCKS : DISK_RESET;
  localparam int FREE_RST = (T_RST > RESERVED_BLOCKS) ? T_RST - RESERVED_BLOCKS : 0;
  localparam logic [WORD_W-1:0] RES_WORD = (WORD_W'(1) << RES_BIT) - WORD_W'(1);

  state_t             state_r, state_nxt;
  logic [LEN_W-1:0]   disk_r;
  logic [LEN_W-1:0]   total;
  logic [LEN_W-1:0]   free_r;
  logic [LEN_W-1:0]   fmt_free;
  logic [LEN_W:0]     free_sum;

  logic [WORD_W-1:0]  mem [ROWS];
  logic [WORD_W-1:0]  mem_q_r;
  logic [RW-1:0]      rd_addr;
  logic               wr_en;
  logic [WORD_W-1:0]  wr_data;
  logic [WORD_W-1:0]  lo_mask;
  logic [WORD_W-1:0]  hi_mask;
  word_res_t          unit_res;

  logic [RW-1:0]      row_r, row_nxt;
  logic [RW-1:0]      first_row_r, first_row_nxt;
  logic [RW-1:0]      last_row_r, last_row_nxt;
  logic [WORD_BW-1:0] lo_bit_r, lo_bit_nxt;
  logic [WORD_BW-1:0] hi_bit_r, hi_bit_nxt;
  logic               rel_r, rel_nxt;
  logic               fmt_r, fmt_nxt;
  status_t            fail_r, fail_nxt;
  status_t            res_status_r, res_status_nxt;
  logic [BLK_W-1:0]   res_start_r, res_start_nxt;
  logic [LEN_W-1:0]   res_len_r, res_len_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic               cnt_v_r;
  logic               out_valid_r;
  res_t               out_data_r;

  logic               accept;
  logic               load_out;
  logic               take_one;
  logic               fmt_load;
  logic [LEN_W:0]     sum_se;
  logic [LEN_W:0]     tot_x;
  logic [LEN_W:0]     rel_end;
  logic [LEN_W-1:0]   rng_lo;
  logic [LEN_W-1:0]   rng_hi;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    total    = (32'(disk_r) > MAX_BLOCKS) ? LEN_W'(MAX_BLOCKS) : disk_r;
    fmt_free = (32'(total) > RESERVED_BLOCKS) ? total - LEN_W'(RESERVED_BLOCKS) : '0;
    free_sum = (LEN_W+1)'(free_r) + (LEN_W+1)'(cnt_r);
    sum_se   = (LEN_W+1)'(in_data.extent_start) + (LEN_W+1)'(in_data.extent_length);
    tot_x    = (LEN_W+1)'(total);
    rel_end  = (sum_se > tot_x) ? tot_x : sum_se;
    unique case (in_data.kind)
      KIND_GROW: begin
        if (in_data.extent_length == '0) begin
          rng_lo = LEN_W'(RESERVED_BLOCKS);
          rng_hi = total - LEN_W'(1);
        end else begin
          rng_lo = sum_se[LEN_W-1:0];
          rng_hi = sum_se[LEN_W-1:0];
        end
      end
      KIND_RELEASE: begin
        rng_lo = LEN_W'(in_data.extent_start);
        rng_hi = LEN_W'(rel_end - (LEN_W+1)'(1));
      end
      default: begin
        rng_lo = '0;
        rng_hi = '0;
      end
    endcase
  end

  always_comb begin
    lo_mask = (row_r == first_row_r) ? ({WORD_W{1'b1}} << lo_bit_r) : {WORD_W{1'b1}};
    hi_mask = (row_r == last_row_r)
            ? ({WORD_W{1'b1}} >> (WORD_BW'(WORD_W - 1) - hi_bit_r)) : {WORD_W{1'b1}};
  end

  ceba_word_unit u_word_unit (
    .word (mem_q_r),
    .mask (lo_mask & hi_mask),
    .res  (unit_res)
  );

  always_comb begin
    state_nxt      = state_r;
    row_nxt        = row_r;
    first_row_nxt  = first_row_r;
    last_row_nxt   = last_row_r;
    lo_bit_nxt     = lo_bit_r;
    hi_bit_nxt     = hi_bit_r;
    rel_nxt        = rel_r;
    fmt_nxt        = fmt_r;
    fail_nxt       = fail_r;
    res_status_nxt = res_status_r;
    res_start_nxt  = res_start_r;
    res_len_nxt    = res_len_r;
    rd_addr        = row_r;
    wr_en          = 1'b0;
    wr_data        = unit_res.cleared;
    take_one       = 1'b0;
    load_out       = 1'b0;
    fmt_load       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        rd_addr = RW'(rng_lo >> WORD_BW);
        if (accept) begin
          res_start_nxt  = in_data.extent_start;
          res_len_nxt    = in_data.extent_length;
          res_status_nxt = ST_OK;
          row_nxt        = RW'(rng_lo >> WORD_BW);
          first_row_nxt  = RW'(rng_lo >> WORD_BW);
          last_row_nxt   = RW'(rng_hi >> WORD_BW);
          lo_bit_nxt     = rng_lo[WORD_BW-1:0];
          hi_bit_nxt     = rng_hi[WORD_BW-1:0];
          unique case (in_data.kind)
            KIND_GROW: begin
              rel_nxt = 1'b0;
              if (in_data.extent_length == '0) begin
                fail_nxt = ST_NO_FREE;
                if (32'(total) <= RESERVED_BLOCKS) begin
                  res_status_nxt = ST_NO_FREE;
                  state_nxt      = S_DONE;
                end else begin
                  state_nxt = S_LOOP;
                end
              end else begin
                fail_nxt = ST_NEXT_TAKEN;
                if (sum_se >= tot_x) begin
                  res_status_nxt = ST_DISK_FULL;
                  state_nxt      = S_DONE;
                end else begin
                  state_nxt = S_LOOP;
                end
              end
            end
            KIND_RELEASE: begin
              rel_nxt     = 1'b1;
              res_len_nxt = '0;
              if (in_data.extent_length != '0) begin
                res_start_nxt = '0;
                if ((LEN_W+1)'(in_data.extent_start) >= rel_end) begin
                  state_nxt = S_DONE;
                end else begin
                  state_nxt = S_LOOP;
                end
              end else begin
                state_nxt = S_DONE;
              end
            end
            KIND_FORMAT: begin
              fmt_nxt       = 1'b1;
              fmt_load      = 1'b1;
              row_nxt       = '0;
              res_start_nxt = '0;
              res_len_nxt   = '0;
              state_nxt     = S_CLEAR;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_LOOP: begin
        rd_addr = (row_r == last_row_r) ? row_r : row_r + RW'(1);
        if (rel_r) begin
          wr_en   = 1'b1;
          wr_data = unit_res.cleared;
          if (row_r == last_row_r) begin
            state_nxt = S_RFIN;
          end else begin
            row_nxt = row_r + RW'(1);
          end
        end else if (unit_res.found) begin
          wr_en    = 1'b1;
          wr_data  = unit_res.claimed;
          take_one = 1'b1;
          if (fail_r == ST_NO_FREE) begin
            res_start_nxt = BLK_W'({row_r, unit_res.idx});
            res_len_nxt   = LEN_W'(1);
          end else begin
            res_len_nxt = res_len_r + LEN_W'(1);
          end
          state_nxt = S_DONE;
        end else if (row_r == last_row_r) begin
          res_status_nxt = fail_r;
          state_nxt      = S_DONE;
        end else begin
          row_nxt = row_r + RW'(1);
        end
      end
      S_RFIN: begin
        state_nxt = S_DONE;
      end
      S_CLEAR: begin
        wr_en = 1'b1;
        if (32'(row_r) < RES_ROW) begin
          wr_data = {WORD_W{1'b1}};
        end else if (32'(row_r) == RES_ROW) begin
          wr_data = RES_WORD;
        end else begin
          wr_data = '0;
        end
        if (row_r == RW'(ROWS - 1)) begin
          state_nxt = fmt_r ? S_DONE : S_IDLE;
          fmt_nxt   = 1'b0;
        end else begin
          row_nxt = row_r + RW'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      row_r   <= '0;
      fmt_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      fmt_r   <= fmt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_row_r  <= first_row_nxt;
    last_row_r   <= last_row_nxt;
    lo_bit_r     <= lo_bit_nxt;
    hi_bit_r     <= hi_bit_nxt;
    rel_r        <= rel_nxt;
    fail_r       <= fail_nxt;
    res_status_r <= res_status_nxt;
    res_start_r  <= res_start_nxt;
    res_len_r    <= res_len_nxt;
    cnt_r        <= unit_res.count;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[row_r] <= wr_data;
    end
    mem_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disk_r <= LEN_W'(DISK_RESET);
    end else if (cfg_we) begin
      disk_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r  <= LEN_W'(FREE_RST);
      cnt_v_r <= 1'b0;
    end else begin
      cnt_v_r <= (state_r == S_LOOP) && rel_r;
      priority if (fmt_load) begin
        free_r <= fmt_free;
      end else if (take_one) begin
        if (free_r != '0) begin
          free_r <= free_r - LEN_W'(1);
        end
      end else if (cnt_v_r && (free_r < total)) begin
        free_r <= (free_sum > tot_x) ? total : free_sum[LEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r.status     <= res_status_r;
      out_data_r.new_start  <= res_start_r;
      out_data_r.new_length <= res_len_r;
      out_data_r.free_count <= free_r;
    end
  end

endmodule

[design/ceba_checker.sv]
// ----------------------------------------------------------------------------
// ceba_checker: port-level checks for the extent block allocator
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
module ceba_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input ceba_pkg::res_t out_data
);
  import ceba_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("request taken during clearing pass");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in work");

  a_no_free_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_NO_FREE) |-> out_data.new_length == '0)
    else $error("no-free status on a non-empty extent");

  a_grow_fail_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_data.status == ST_DISK_FULL) || (out_data.status == ST_NEXT_TAKEN))
      |-> out_data.new_length != '0)
    else $error("extend failure on an empty extent");

endmodule

bind contiguous_extent_block_allocator ceba_checker u_ceba_checker (.*);
